[hdl/f2hp_pkg.sv]
// ----------------------------------------------------------------------------
// f2hp_pkg: shared types and constants
// Field widths, constant half patterns and the classification codes used by
// the single-to-half conversion pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package f2hp_pkg;

	localparam int unsigned FloatW = 32;
	localparam int unsigned HalfW  = 16;
	localparam int unsigned FracW  = 23;
	localparam int unsigned ExpW   = 8;
	localparam int unsigned HExpW  = 5;
	localparam int unsigned MantW  = 11;
	localparam int unsigned ShW    = 5;

	localparam logic [ExpW-1:0]  ExpAllOnes = 8'd255;
	localparam logic [ExpW-1:0]  ExpOvf     = 8'd143;
	localparam logic [ExpW-1:0]  ExpMinNorm = 8'd113;
	localparam logic [ExpW-1:0]  ExpMinSub  = 8'd102;
	localparam logic [ExpW-1:0]  ExpRebias  = 8'd112;
	localparam logic [ExpW-1:0]  ShBase     = 8'd126;
	localparam logic [HExpW-1:0] HExpMax    = 5'd31;

	localparam logic [HalfW-2:0] HalfInf    = 15'h7C00;
	localparam logic [HalfW-2:0] HalfQnan   = 15'h7E00;
	localparam logic [FracW-1:0] RoundNorm  = 23'h001000;

	typedef enum logic [2:0] {
		CLS_ZERO = 3'd0,
		CLS_SUB  = 3'd1,
		CLS_NORM = 3'd2,
		CLS_INF  = 3'd3,
		CLS_NAN  = 3'd4
	} cls_t;

	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
	} stage_en_t;

endpackage

`default_nettype wire

[hdl/f2hp_lane.sv]
// ----------------------------------------------------------------------------
// f2hp_lane: one single-to-half conversion lane
// Stage 1 classifies the input, stage 2 rounds the significand, stage 3
// assembles the half pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module f2hp_lane (
	input  wire logic                          clk,
	input  wire f2hp_pkg::stage_en_t           en,
	input  wire logic [f2hp_pkg::FloatW-1:0]   float_bits,
	output logic      [f2hp_pkg::HalfW-1:0]    half_bits
);

	logic                          sign_in;
	logic [f2hp_pkg::ExpW-1:0]     exp_in;
	logic [f2hp_pkg::FracW-1:0]    frac_in;
	f2hp_pkg::cls_t                cls_in;
	logic [f2hp_pkg::ExpW-1:0]     sh_full;

	logic                          sign_s1;
	f2hp_pkg::cls_t                cls_s1;
	logic [f2hp_pkg::FracW-1:0]    frac_s1;
	logic [f2hp_pkg::ShW-1:0]      sh_s1;
	logic [f2hp_pkg::HExpW-1:0]    hexp_s1;

	logic [f2hp_pkg::FracW+1:0]    sub_sum;
	logic [f2hp_pkg::FracW+1:0]    sub_shift;
	logic [f2hp_pkg::FracW:0]      norm_sum;
	logic [f2hp_pkg::MantW-1:0]    mant_c2;

	logic                          sign_s2;
	f2hp_pkg::cls_t                cls_s2;
	logic [f2hp_pkg::MantW-1:0]    mant_s2;
	logic [f2hp_pkg::HExpW-1:0]    hexp_s2;

	logic [f2hp_pkg::HExpW-1:0]    hexp_inc;
	logic [f2hp_pkg::HalfW-2:0]    mag_c3;
	logic [f2hp_pkg::HalfW-1:0]    half_s3;

	assign sign_in = float_bits[f2hp_pkg::FloatW-1];
	assign exp_in  = float_bits[f2hp_pkg::FloatW-2:f2hp_pkg::FracW];
	assign frac_in = float_bits[f2hp_pkg::FracW-1:0];
	assign sh_full = f2hp_pkg::ShBase - exp_in;

	always_comb begin
		if (exp_in == f2hp_pkg::ExpAllOnes) begin
			cls_in = (frac_in != '0) ? f2hp_pkg::CLS_NAN : f2hp_pkg::CLS_INF;
		end else if (exp_in >= f2hp_pkg::ExpOvf) begin
			cls_in = f2hp_pkg::CLS_INF;
		end else if (exp_in >= f2hp_pkg::ExpMinNorm) begin
			cls_in = f2hp_pkg::CLS_NORM;
		end else if (exp_in >= f2hp_pkg::ExpMinSub) begin
			cls_in = f2hp_pkg::CLS_SUB;
		end else begin
			cls_in = f2hp_pkg::CLS_ZERO;
		end
	end

	always_ff @(posedge clk) begin
		if (en.en_s1) begin
			sign_s1 <= sign_in;
			cls_s1  <= cls_in;
			frac_s1 <= frac_in;
			sh_s1   <= sh_full[f2hp_pkg::ShW-1:0];
			hexp_s1 <= f2hp_pkg::HExpW'(exp_in - f2hp_pkg::ExpRebias);
		end
	end

	always_comb begin
		sub_sum   = {2'b01, frac_s1} + ((f2hp_pkg::FracW+2)'(1) << (sh_s1 - 5'd1));
		sub_shift = sub_sum >> sh_s1;
		norm_sum  = {1'b0, frac_s1} + {1'b0, f2hp_pkg::RoundNorm};
		if (cls_s1 == f2hp_pkg::CLS_SUB) begin
			mant_c2 = sub_shift[f2hp_pkg::MantW-1:0];
		end else begin
			mant_c2 = norm_sum[f2hp_pkg::FracW:f2hp_pkg::FracW-f2hp_pkg::MantW+1];
		end
	end

	always_ff @(posedge clk) begin
		if (en.en_s2) begin
			sign_s2 <= sign_s1;
			cls_s2  <= cls_s1;
			mant_s2 <= mant_c2;
			hexp_s2 <= hexp_s1;
		end
	end

	assign hexp_inc = hexp_s2 + 5'd1;

	always_comb begin
		case (cls_s2)
			f2hp_pkg::CLS_ZERO: mag_c3 = '0;
			f2hp_pkg::CLS_SUB:  mag_c3 = {4'b0, mant_s2};
			f2hp_pkg::CLS_NORM: begin
				if (!mant_s2[f2hp_pkg::MantW-1]) begin
					mag_c3 = {hexp_s2, mant_s2[f2hp_pkg::MantW-2:0]};
				end else if (hexp_inc == f2hp_pkg::HExpMax) begin
					mag_c3 = f2hp_pkg::HalfInf;
				end else begin
					mag_c3 = {hexp_inc, 10'b0};
				end
			end
			f2hp_pkg::CLS_INF:  mag_c3 = f2hp_pkg::HalfInf;
			f2hp_pkg::CLS_NAN:  mag_c3 = f2hp_pkg::HalfQnan;
			default:            mag_c3 = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en.en_s3) begin
			half_s3 <= {sign_s2, mag_c3};
		end
	end

	assign half_bits = half_s3;

endmodule

`default_nettype wire

[hdl/f2hp_ctrl.sv]
// ----------------------------------------------------------------------------
// f2hp_ctrl: pipeline valid bits and stage enables
// Each stage loads when it is empty or when the stage after it moves on, so
// bubbles close up and a stall at the output loses nothing.
// ----------------------------------------------------------------------------
`default_nettype none

module f2hp_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire logic           out_ready,
	output f2hp_pkg::stage_en_t en
);

	logic v_s1;
	logic v_s2;
	logic v_s3;

	logic load_first;
	logic load_second;
	logic load_third;

	assign load_third  = !v_s3 || out_ready;
	assign load_second = !v_s2 || load_third;
	assign load_first  = !v_s1 || load_second;
	assign en = '{en_s1: load_first, en_s2: load_second, en_s3: load_third};
	assign in_ready  = load_first;
	assign out_valid = v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (load_first) v_s1 <= in_valid;
			if (load_second) v_s2 <= v_s1;
			if (load_third) v_s3 <= v_s2;
		end
	end

	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> in_ready)
		else $error("Empty first stage refused a request.");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s1)
		else $error("Accepted request did not reach the first stage.");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && v_s3 && !out_ready |=> v_s2 && v_s3)
		else $error("Stalled request was dropped inside the pipeline.");

endmodule

`default_nettype wire

[hdl/float32_pair_to_half_pack.sv]
// ----------------------------------------------------------------------------
// float32_pair_to_half_pack: two singles to one packed half pair
//
// Channel   Dir  tdata                                   Width
// s_axis    in   low_float_bits[31:0], high_float_bits   64
// m_axis    out  packed_halves                           32
//
// A request accepted at the input passes through the classify, round and
// assemble register stages in that order before it can leave on m_axis.
// One request is accepted per cycle when the output is taken steadily.
// Reset clears only the stage valid bits; data registers are not reset.
// An output stall holds each stage, and empty stages still take requests.
// ----------------------------------------------------------------------------
`default_nettype none

module float32_pair_to_half_pack (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// low_float_bits [31:0], high_float_bits [63:32]
	input  wire logic [63:0] s_axis_tdata,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// packed_halves [31:0]
	output logic      [31:0] m_axis_tdata
);

	f2hp_pkg::stage_en_t en;

	f2hp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.en        (en)
	);

	f2hp_lane u_lane_lo (
		.clk        (clk),
		.en         (en),
		.float_bits (s_axis_tdata[31:0]),
		.half_bits  (m_axis_tdata[15:0])
	);

	f2hp_lane u_lane_hi (
		.clk        (clk),
		.en         (en),
		.float_bits (s_axis_tdata[63:32]),
		.half_bits  (m_axis_tdata[31:16])
	);

endmodule

`default_nettype wire
